// ----- hdl/pstc_pkg.sv -----
// Shared constants, codes and types of the pixel saturation and tone curve block.
package pstc_pkg;

    localparam int unsigned CHAN_W      = 8;
    localparam int unsigned NUM_CHAN    = 3;
    localparam int unsigned ADDR_W      = 11;
    localparam int unsigned VIVID_W     = 9;
    localparam int unsigned STORE_DEPTH = 1280;
    localparam int unsigned TABLE_SIZE  = 256;
    localparam int unsigned PAGE_W      = 3;

    // Luma weights of the gray value, in 1/256 units.
    localparam logic [7:0] LUMA_R = 8'd77;
    localparam logic [7:0] LUMA_G = 8'd151;
    localparam logic [7:0] LUMA_B = 8'd28;

    localparam logic [VIVID_W-1:0] FULL_WEIGHT = 9'd256;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_PIXEL = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CURVE_BYPASS  = 2'd0,
        CURVE_SHARED  = 2'd1,
        CURVE_CHANNEL = 2'd2,
        CURVE_CHAIN   = 2'd3
    } curve_mode_t;

    typedef enum logic {
        REG_CURVE_MODE = 1'b0,
        REG_VIVIDNESS  = 1'b1
    } reg_index_t;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef chan_t [NUM_CHAN-1:0] rgb_t;

    // Control bits that travel with every pipeline slot.
    typedef struct packed {
        logic valid;
        logic pixel;
    } stage_ctl_t;

    // Curve store write carried by a table write transaction.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        chan_t             data;
    } table_wr_t;

endpackage

// ----- hdl/pstc_blend.sv -----
// Gray value and saturation blend: the first two pipeline stages.
module pstc_blend (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic [pstc_pkg::VIVID_W-1:0]  vividness,
    input  pstc_pkg::stage_ctl_t          in_ctl,
    input  pstc_pkg::rgb_t                in_rgb,
    input  pstc_pkg::chan_t               in_alpha,
    input  pstc_pkg::table_wr_t           in_wr,
    output pstc_pkg::stage_ctl_t          out_ctl,
    output pstc_pkg::rgb_t                out_rgb,
    output pstc_pkg::chan_t               out_alpha,
    output pstc_pkg::table_wr_t           out_wr
);

    pstc_pkg::stage_ctl_t ctl1_reg, ctl2_reg;
    pstc_pkg::rgb_t       rgb1_reg, rgb2_reg;
    pstc_pkg::chan_t      alpha1_reg, alpha2_reg;
    pstc_pkg::table_wr_t  wr1_reg, wr2_reg;
    pstc_pkg::chan_t      gray1_reg;

    logic [15:0]                   gray_sum;
    logic                          keep_colour;
    logic [pstc_pkg::VIVID_W-1:0]  colour_weight;
    logic [pstc_pkg::VIVID_W-1:0]  gray_weight;
    logic [15:0]                   blend_sum [pstc_pkg::NUM_CHAN];
    pstc_pkg::rgb_t                rgb2_next;

    assign gray_sum = 16'(in_rgb[0]) * 16'(pstc_pkg::LUMA_R)
                    + 16'(in_rgb[1]) * 16'(pstc_pkg::LUMA_G)
                    + 16'(in_rgb[2]) * 16'(pstc_pkg::LUMA_B);

    // Any weight of 256 or more leaves the colour unchanged.
    assign keep_colour   = vividness[pstc_pkg::VIVID_W-1];
    assign colour_weight = {1'b0, vividness[pstc_pkg::VIVID_W-2:0]};
    assign gray_weight   = pstc_pkg::FULL_WEIGHT - colour_weight;

    always_comb begin
        for (int i = 0; i < pstc_pkg::NUM_CHAN; i++) begin
            blend_sum[i] = 16'(gray1_reg) * 16'(gray_weight)
                         + 16'(rgb1_reg[i]) * 16'(colour_weight);
            rgb2_next[i] = keep_colour ? rgb1_reg[i] : blend_sum[i][15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end else if (en) begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rgb1_reg   <= in_rgb;
            alpha1_reg <= in_alpha;
            wr1_reg    <= in_wr;
            gray1_reg  <= gray_sum[15:8];
            rgb2_reg   <= rgb2_next;
            alpha2_reg <= alpha1_reg;
            wr2_reg    <= wr1_reg;
        end
    end

    assign out_ctl   = ctl2_reg;
    assign out_rgb   = rgb2_reg;
    assign out_alpha = alpha2_reg;
    assign out_wr    = wr2_reg;

endmodule

// ----- hdl/pstc_curve.sv -----
// Tone curve lookup: curve store copies per channel, first and chained reads.
module pstc_curve (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  pstc_pkg::curve_mode_t mode,
    input  pstc_pkg::stage_ctl_t  in_ctl,
    input  pstc_pkg::rgb_t        in_rgb,
    input  pstc_pkg::chan_t       in_alpha,
    input  pstc_pkg::table_wr_t   in_wr,
    output pstc_pkg::stage_ctl_t  out_ctl,
    output pstc_pkg::rgb_t        out_rgb,
    output pstc_pkg::chan_t       out_alpha
);

    pstc_pkg::stage_ctl_t ctl3_reg, ctl4_reg;
    pstc_pkg::rgb_t       chan3_reg, chan4_reg;
    pstc_pkg::chan_t      alpha3_reg, alpha4_reg;
    pstc_pkg::table_wr_t  wr3_reg;

    logic first_we;
    logic second_we;

    // Each copy is written when the write transaction passes its read point, so
    // pixels ahead of it see the old byte and pixels behind it the new one.
    assign first_we  = en && in_ctl.valid && !in_ctl.pixel
                       && (32'(in_wr.addr) < pstc_pkg::STORE_DEPTH);
    assign second_we = en && ctl3_reg.valid && !ctl3_reg.pixel
                       && (32'(wr3_reg.addr) < pstc_pkg::TABLE_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end else if (en) begin
            ctl3_reg <= in_ctl;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            chan3_reg  <= in_rgb;
            alpha3_reg <= in_alpha;
            wr3_reg    <= in_wr;
            chan4_reg  <= chan3_reg;
            alpha4_reg <= alpha3_reg;
        end
    end

    for (genvar lane = 0; lane < pstc_pkg::NUM_CHAN; lane++) begin : g_lane
        pstc_pkg::chan_t               first_mem [pstc_pkg::STORE_DEPTH];
        pstc_pkg::chan_t               second_mem [pstc_pkg::TABLE_SIZE];
        pstc_pkg::chan_t               first_rd_reg;
        pstc_pkg::chan_t               first4_reg;
        pstc_pkg::chan_t               second_rd_reg;
        logic [pstc_pkg::PAGE_W-1:0]   page;
        logic [pstc_pkg::ADDR_W-1:0]   first_addr;

        always_comb begin
            case (mode)
                pstc_pkg::CURVE_CHANNEL: page = pstc_pkg::PAGE_W'(lane);
                pstc_pkg::CURVE_CHAIN:   page = pstc_pkg::PAGE_W'(lane + 1);
                default:                 page = '0;
            endcase
        end

        assign first_addr = {page, in_rgb[lane]};

        always_ff @(posedge aclk) begin
            if (first_we) begin
                first_mem[in_wr.addr] <= in_wr.data;
            end
            if (en) begin
                first_rd_reg <= first_mem[first_addr];
            end
        end

        always_ff @(posedge aclk) begin
            if (second_we) begin
                second_mem[wr3_reg.addr[pstc_pkg::CHAN_W-1:0]] <= wr3_reg.data;
            end
            if (en) begin
                second_rd_reg <= second_mem[first_rd_reg];
                first4_reg    <= first_rd_reg;
            end
        end

        always_comb begin
            case (mode)
                pstc_pkg::CURVE_BYPASS:  out_rgb[lane] = chan4_reg[lane];
                pstc_pkg::CURVE_SHARED:  out_rgb[lane] = first4_reg;
                pstc_pkg::CURVE_CHANNEL: out_rgb[lane] = first4_reg;
                pstc_pkg::CURVE_CHAIN:   out_rgb[lane] = second_rd_reg;
                default:                 out_rgb[lane] = chan4_reg[lane];
            endcase
        end
    end

    assign out_ctl   = ctl4_reg;
    assign out_alpha = alpha4_reg;

endmodule

// ----- hdl/pstc_skid.sv -----
// Output register with a skid stage so that input readiness never waits on m_ready.
module pstc_skid (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  pstc_pkg::rgb_t  in_rgb,
    input  pstc_pkg::chan_t in_alpha,
    output logic            space,
    output logic            m_valid,
    input  logic            m_ready,
    output pstc_pkg::rgb_t  m_rgb,
    output pstc_pkg::chan_t m_alpha
);

    logic            out_valid_reg;
    logic            skid_valid_reg;
    pstc_pkg::rgb_t  out_rgb_reg, skid_rgb_reg;
    pstc_pkg::chan_t out_alpha_reg, skid_alpha_reg;
    logic            push;
    logic            out_free;

    assign space    = !skid_valid_reg;
    assign push     = in_valid && space;
    assign out_free = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_rgb_reg   <= skid_rgb_reg;
                out_alpha_reg <= skid_alpha_reg;
            end else begin
                out_rgb_reg   <= in_rgb;
                out_alpha_reg <= in_alpha;
            end
        end else if (push) begin
            skid_rgb_reg   <= in_rgb;
            skid_alpha_reg <= in_alpha;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_rgb   = out_rgb_reg;
    assign m_alpha = out_alpha_reg;

endmodule

// ----- hdl/pixel_saturation_tone_curve.sv -----
// Top level of the pixel saturation blend and tone curve block.
//
// The s_ channel carries one transaction per clock while s_ready is high:
// either a curve store write (s_op low, s_table_addr and s_table_data) or an
// RGBA pixel (s_op high). Every pixel yields exactly one transaction on the m_
// channel, in order; a table write yields none. Writes to addresses of 1280 or
// above are dropped. The user must write configuration through cfg_wr_en,
// cfg_index and cfg_wr_data only while the pipeline is empty; the block does
// not enforce this. Index 0 selects the curve mode, index 1 the vividness weight.
// A pixel accepted on s_ passes these stages before it appears on m_valid: two
// stages form the gray value and the blend, two more perform the first and the
// chained curve store reads, and the output register follows. One transaction
// is taken every clock while s_ready is high; the curve store is copied per
// channel so that all three channels and the chained lookup read together.
// When the receiver holds m_ready low, a finished pixel lands in the skid stage
// and s_ready falls in the next cycle, freezing the whole pipeline in place;
// nothing is lost or repeated. s_ready depends only on registers.
// Synchronous reset empties the pipeline and restores bypass mode and full
// vividness. The curve store is not cleared and must be loaded before use.
module pixel_saturation_tone_curve (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [pstc_pkg::VIVID_W-1:0]  cfg_wr_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_op,
    input  logic [pstc_pkg::ADDR_W-1:0]   s_table_addr,
    input  logic [7:0]                    s_table_data,
    input  logic [7:0]                    s_red_in,
    input  logic [7:0]                    s_green_in,
    input  logic [7:0]                    s_blue_in,
    input  logic [7:0]                    s_alpha_in,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [7:0]                    m_red_out,
    output logic [7:0]                    m_green_out,
    output logic [7:0]                    m_blue_out,
    output logic [7:0]                    m_alpha_out
);

    pstc_pkg::curve_mode_t         curve_mode_reg;
    logic [pstc_pkg::VIVID_W-1:0]  vividness_reg;

    logic                  en;
    pstc_pkg::stage_ctl_t  in_ctl;
    pstc_pkg::rgb_t        in_rgb;
    pstc_pkg::table_wr_t   in_wr;

    pstc_pkg::stage_ctl_t  blend_ctl;
    pstc_pkg::rgb_t        blend_rgb;
    pstc_pkg::chan_t       blend_alpha;
    pstc_pkg::table_wr_t   blend_wr;

    pstc_pkg::stage_ctl_t  curve_ctl;
    pstc_pkg::rgb_t        curve_rgb;
    pstc_pkg::chan_t       curve_alpha;

    pstc_pkg::rgb_t        m_rgb;

    // Configuration registers; a write to an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_mode_reg <= pstc_pkg::CURVE_BYPASS;
            vividness_reg  <= pstc_pkg::FULL_WEIGHT;
        end else if (cfg_wr_en) begin
            case (pstc_pkg::reg_index_t'(cfg_index))
                pstc_pkg::REG_CURVE_MODE:
                    curve_mode_reg <= pstc_pkg::curve_mode_t'(cfg_wr_data[1:0]);
                pstc_pkg::REG_VIVIDNESS:
                    vividness_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline advances together whenever the skid stage is empty.
    assign s_ready      = en;
    assign in_ctl.valid = s_valid;
    assign in_ctl.pixel = (pstc_pkg::op_t'(s_op) == pstc_pkg::OP_PIXEL);
    assign in_rgb       = {s_blue_in, s_green_in, s_red_in};
    assign in_wr.addr   = s_table_addr;
    assign in_wr.data   = s_table_data;

    pstc_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .vividness (vividness_reg),
        .in_ctl    (in_ctl),
        .in_rgb    (in_rgb),
        .in_alpha  (s_alpha_in),
        .in_wr     (in_wr),
        .out_ctl   (blend_ctl),
        .out_rgb   (blend_rgb),
        .out_alpha (blend_alpha),
        .out_wr    (blend_wr)
    );

    pstc_curve u_curve (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .mode      (curve_mode_reg),
        .in_ctl    (blend_ctl),
        .in_rgb    (blend_rgb),
        .in_alpha  (blend_alpha),
        .in_wr     (blend_wr),
        .out_ctl   (curve_ctl),
        .out_rgb   (curve_rgb),
        .out_alpha (curve_alpha)
    );

    // Only pixel transactions reach the output; table writes end in the store.
    pstc_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (curve_ctl.valid && curve_ctl.pixel),
        .in_rgb   (curve_rgb),
        .in_alpha (curve_alpha),
        .space    (en),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_rgb    (m_rgb),
        .m_alpha  (m_alpha_out)
    );

    assign m_red_out   = m_rgb[0];
    assign m_green_out = m_rgb[1];
    assign m_blue_out  = m_rgb[2];

endmodule

// ----- bench/tb_pixel_saturation_tone_curve.sv -----
// Self-checking testbench for the pixel saturation blend and tone curve block.
module tb_pixel_saturation_tone_curve;
    timeunit 1ns;
    timeprecision 1ps;

    // The clock period is 8 ns and reset is held low at the start of the run.
    localparam int unsigned RESET_CYCLES   = 7;
    // Margin after the last pixel has returned, so that a trailing table write
    // has certainly landed in both store copies before any register is touched.
    localparam int unsigned DRAIN_CYCLES   = 8;
    // The random traffic is spread over three idling regimes of four phases.
    localparam int unsigned RANDOM_ITEMS   = 240;
    localparam int unsigned PHASES         = 12;
    // Cycles without any transaction on either channel before the run is
    // declared hung. With 76 per cent idling a gap of this length is
    // practically impossible in a correct run.
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    // One result transaction as the predictor expects it.
    typedef struct packed {
        pstc_pkg::chan_t red;
        pstc_pkg::chan_t green;
        pstc_pkg::chan_t blue;
        pstc_pkg::chan_t alpha;
    } rgba_t;

    logic                           aclk         = 1'b0;
    logic                           aresetn      = 1'b0;
    logic                           cfg_wr_en    = 1'b0;
    logic                           cfg_index    = pstc_pkg::REG_CURVE_MODE;
    logic [pstc_pkg::VIVID_W-1:0]   cfg_wr_data  = '0;
    logic                           s_valid      = 1'b0;
    logic                           s_ready;
    logic                           s_op         = pstc_pkg::OP_WRITE;
    logic [pstc_pkg::ADDR_W-1:0]    s_table_addr = '0;
    logic [7:0]                     s_table_data = '0;
    logic [7:0]                     s_red_in     = '0;
    logic [7:0]                     s_green_in   = '0;
    logic [7:0]                     s_blue_in    = '0;
    logic [7:0]                     s_alpha_in   = '0;
    logic                           m_valid;
    logic                           m_ready      = 1'b0;
    logic [7:0]                     m_red_out;
    logic [7:0]                     m_green_out;
    logic [7:0]                     m_blue_out;
    logic [7:0]                     m_alpha_out;

    // Our own copy of the block's state and registers, updated in acceptance
    // order so that every pixel sees exactly the curve bytes written before it.
    pstc_pkg::chan_t                curve_copy [pstc_pkg::STORE_DEPTH];
    pstc_pkg::curve_mode_t          mode_shadow   = pstc_pkg::CURVE_BYPASS;
    logic [pstc_pkg::VIVID_W-1:0]   vivid_shadow  = pstc_pkg::FULL_WEIGHT;

    rgba_t                          expected_pixels [$];
    int unsigned                    error_count    = 0;
    int unsigned                    send_idle_pct  = 7;
    int unsigned                    recv_idle_pct  = 76;

    pixel_saturation_tone_curve uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_table_addr (s_table_addr),
        .s_table_data (s_table_data),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .s_alpha_in   (s_alpha_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out),
        .m_alpha_out  (m_alpha_out)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Maps one blended level of one colour channel through the selected curve.
    // In chained mode the per-channel byte indexes the shared table in turn.
    function automatic int unsigned curve_level(int unsigned level, int unsigned chan);
        logic [pstc_pkg::ADDR_W-1:0] lvl;
        logic [pstc_pkg::ADDR_W-1:0] page;
        logic [pstc_pkg::ADDR_W-1:0] chain_addr;
        lvl        = pstc_pkg::ADDR_W'(level);
        page       = pstc_pkg::ADDR_W'(chan * pstc_pkg::TABLE_SIZE);
        chain_addr = pstc_pkg::ADDR_W'(pstc_pkg::TABLE_SIZE) + page + lvl;
        case (mode_shadow)
            pstc_pkg::CURVE_SHARED:  return 32'(curve_copy[lvl]);
            pstc_pkg::CURVE_CHANNEL: return 32'(curve_copy[page + lvl]);
            pstc_pkg::CURVE_CHAIN:
                return 32'(curve_copy[pstc_pkg::ADDR_W'(curve_copy[chain_addr])]);
            default:                 return level;
        endcase
    endfunction

    // Blends the colour toward its luma by the vividness weight, then applies
    // the tone curve. A weight above full scale behaves as full scale, and at
    // full scale the blend is skipped altogether.
    function automatic rgba_t tone_map_pixel(pstc_pkg::chan_t red, pstc_pkg::chan_t green,
                                             pstc_pkg::chan_t blue, pstc_pkg::chan_t alpha);
        int unsigned level [pstc_pkg::NUM_CHAN];
        int unsigned gray;
        int unsigned weight;
        rgba_t       px;
        level[0] = 32'(red);
        level[1] = 32'(green);
        level[2] = 32'(blue);
        weight = (vivid_shadow > pstc_pkg::FULL_WEIGHT) ? 32'(pstc_pkg::FULL_WEIGHT)
                                                        : 32'(vivid_shadow);
        if (weight != 32'(pstc_pkg::FULL_WEIGHT)) begin
            gray = (level[0] * pstc_pkg::LUMA_R + level[1] * pstc_pkg::LUMA_G
                    + level[2] * pstc_pkg::LUMA_B) >> 8;
            for (int i = 0; i < pstc_pkg::NUM_CHAN; i++) begin
                level[i] = ((gray * (32'(pstc_pkg::FULL_WEIGHT) - weight)
                             + level[i] * weight) >> 8) & 32'hFF;
            end
        end
        px.red   = pstc_pkg::chan_t'(curve_level(level[0], 0));
        px.green = pstc_pkg::chan_t'(curve_level(level[1], 1));
        px.blue  = pstc_pkg::chan_t'(curve_level(level[2], 2));
        px.alpha = alpha;
        return px;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // The block's outputs only move on the rising edge, so sampling on the
    // falling edge sees the values that the next rising edge will accept.
    always @(negedge aclk) begin : check_result
        rgba_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("pixel with no pending expectation", 32'(m_red_out), 0);
            end else begin
                want = expected_pixels.pop_front();
                if (m_red_out !== want.red)
                    report_mismatch("red_out", 32'(m_red_out), 32'(want.red));
                if (m_green_out !== want.green)
                    report_mismatch("green_out", 32'(m_green_out), 32'(want.green));
                if (m_blue_out !== want.blue)
                    report_mismatch("blue_out", 32'(m_blue_out), 32'(want.blue));
                if (m_alpha_out !== want.alpha)
                    report_mismatch("alpha_out", 32'(m_alpha_out), 32'(want.alpha));
            end
        end
    end

    // The receiver stalls at random; a stall percentage of zero gives a
    // stretch with the result channel always ready.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Gives up when neither channel nor the register port has moved for
    // too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(negedge aclk);
            if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_pixel_saturation_tone_curve: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Presents one transaction on the input channel, optionally after a random
    // idle gap, and holds it until it is taken. The prediction is made on the
    // falling edge just before the accepting rising edge. The task returns in
    // the time step of that edge with valid still high, so a following
    // transaction goes out back to back without valid ever dropping.
    task automatic send_item(pstc_pkg::op_t op, logic [pstc_pkg::ADDR_W-1:0] addr,
                             pstc_pkg::chan_t data, pstc_pkg::chan_t red,
                             pstc_pkg::chan_t green, pstc_pkg::chan_t blue,
                             pstc_pkg::chan_t alpha);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_table_addr <= addr;
        s_table_data <= data;
        s_red_in     <= red;
        s_green_in   <= green;
        s_blue_in    <= blue;
        s_alpha_in   <= alpha;
        do @(negedge aclk); while (!s_ready);
        if (op == pstc_pkg::OP_WRITE) begin
            // Writes beyond the store are dropped by the block.
            if (32'(addr) < pstc_pkg::STORE_DEPTH)
                curve_copy[addr] = data;
        end else begin
            expected_pixels.insert(expected_pixels.size(),
                                   tone_map_pixel(red, green, blue, alpha));
        end
        @(posedge aclk);
    endtask

    // A table write carries random pixel fields, which the block must ignore.
    task automatic write_curve(logic [pstc_pkg::ADDR_W-1:0] addr, pstc_pkg::chan_t data);
        send_item(pstc_pkg::OP_WRITE, addr, data,
                  pstc_pkg::chan_t'($urandom), pstc_pkg::chan_t'($urandom),
                  pstc_pkg::chan_t'($urandom), pstc_pkg::chan_t'($urandom));
    endtask

    // A pixel carries random table fields, which the block must ignore.
    task automatic send_pixel(pstc_pkg::chan_t red, pstc_pkg::chan_t green,
                              pstc_pkg::chan_t blue, pstc_pkg::chan_t alpha);
        send_item(pstc_pkg::OP_PIXEL, pstc_pkg::ADDR_W'($urandom),
                  pstc_pkg::chan_t'($urandom), red, green, blue, alpha);
    endtask

    // Stops sending and waits until every pixel has come back and any trailing
    // table write has passed through the pipeline.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes both registers while the block is idle. The write enable stays
    // high across the two back-to-back writes and falls afterwards.
    task automatic configure(pstc_pkg::curve_mode_t mode,
                             logic [pstc_pkg::VIVID_W-1:0] vivid);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= pstc_pkg::REG_CURVE_MODE;
        cfg_wr_data <= pstc_pkg::VIVID_W'(mode);
        @(posedge aclk);
        mode_shadow = mode;
        cfg_index   <= pstc_pkg::REG_VIVIDNESS;
        cfg_wr_data <= vivid;
        @(posedge aclk);
        vivid_shadow = vivid;
        cfg_wr_en   <= 1'b0;
    endtask

    // Random pixel: mostly uniform, now and then built from the extreme levels.
    task automatic send_random_pixel();
        if ($urandom_range(7) == 0)
            send_pixel({8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}},
                       {8{1'($urandom_range(1))}}, {8{1'($urandom_range(1))}});
        else
            send_pixel(pstc_pkg::chan_t'($urandom), pstc_pkg::chan_t'($urandom),
                       pstc_pkg::chan_t'($urandom), pstc_pkg::chan_t'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Bypass mode straight out of reset checks the reset values of both
    // registers; then full gray, a weight above full scale and the smallest
    // non-zero weight. The curve store is not read in bypass mode, so these
    // run before anything has been loaded.
    task automatic test_bypass_blend();
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd255, 8'd0, 8'd0, 8'd128);
        send_pixel(8'd0, 8'd255, 8'd0, 8'd1);
        configure(pstc_pkg::CURVE_BYPASS, 9'd0);
        send_pixel(8'd255, 8'd0, 8'd0, 8'd7);
        send_pixel(8'd0, 8'd255, 8'd0, 8'd77);
        send_pixel(8'd0, 8'd0, 8'd255, 8'd254);
        configure(pstc_pkg::CURVE_BYPASS, 9'd511);
        send_pixel(8'd12, 8'd200, 8'd56, 8'd99);
        configure(pstc_pkg::CURVE_BYPASS, 9'd1);
        send_pixel(8'd255, 8'd17, 8'd0, 8'd255);
    endtask

    // Loads the whole curve store, so that no later pixel can read an entry
    // that has never been written. Writes past the end of the store, up to
    // the largest address the port can carry, must leave it untouched.
    task automatic test_curve_load();
        for (int unsigned a = 0; a < pstc_pkg::STORE_DEPTH; a++)
            write_curve(pstc_pkg::ADDR_W'(a), pstc_pkg::chan_t'($urandom));
        write_curve(pstc_pkg::ADDR_W'(pstc_pkg::STORE_DEPTH), pstc_pkg::chan_t'($urandom));
        write_curve('1, pstc_pkg::chan_t'($urandom));
        write_curve(pstc_pkg::ADDR_W'($urandom_range(2046, pstc_pkg::STORE_DEPTH + 1)),
                    pstc_pkg::chan_t'($urandom));
    endtask

    // Every curve mode other than bypass with extreme and mixed pixels, and
    // the chained curve once more behind a blend.
    task automatic test_curve_modes();
        configure(pstc_pkg::CURVE_SHARED, pstc_pkg::FULL_WEIGHT);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        configure(pstc_pkg::CURVE_CHANNEL, pstc_pkg::FULL_WEIGHT);
        send_pixel(8'd0, 8'd128, 8'd255, 8'd33);
        send_pixel(8'd255, 8'd1, 8'd0, 8'd200);
        configure(pstc_pkg::CURVE_CHAIN, pstc_pkg::FULL_WEIGHT);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
        send_pixel(8'd90, 8'd180, 8'd45, 8'd60);
        configure(pstc_pkg::CURVE_CHAIN, 9'd255);
        send_pixel(8'd255, 8'd0, 8'd128, 8'd10);
    endtask

    // Random traffic under three idling regimes. Every phase picks a new
    // setting, cycling through all curve modes and through the extreme
    // weights before random ones. Within a phase most transactions are
    // pixels; the rest rewrite curve bytes mid-stream, a few of them beyond
    // the end of the store.
    task automatic test_random_traffic();
        int unsigned                  per_phase;
        logic [pstc_pkg::VIVID_W-1:0] vivid;
        per_phase = RANDOM_ITEMS / PHASES;
        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            case (phase / (PHASES / 3))
                0: begin
                    send_idle_pct = 7;
                    recv_idle_pct = 76;
                end
                1: begin
                    send_idle_pct = 76;
                    recv_idle_pct = 7;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (phase)
                0:       vivid = 9'd0;
                1:       vivid = pstc_pkg::FULL_WEIGHT;
                2:       vivid = 9'd511;
                3:       vivid = 9'd1;
                4:       vivid = 9'd255;
                5:       vivid = 9'd257;
                default: vivid = pstc_pkg::VIVID_W'($urandom_range(511));
            endcase
            configure(pstc_pkg::curve_mode_t'(phase % 4), vivid);
            for (int unsigned n = 0; n < per_phase; n++) begin
                if ($urandom_range(99) < 85)
                    send_random_pixel();
                else if ($urandom_range(9) == 0)
                    write_curve(pstc_pkg::ADDR_W'($urandom_range(2047,
                                                                 pstc_pkg::STORE_DEPTH)),
                                pstc_pkg::chan_t'($urandom));
                else
                    write_curve(pstc_pkg::ADDR_W'($urandom_range(pstc_pkg::STORE_DEPTH - 1)),
                                pstc_pkg::chan_t'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        curve_copy = '{default: '0};
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_bypass_blend();
        test_curve_load();
        test_curve_modes();
        test_random_traffic();

        // Everything has been sent: let the last pixels come back and leave a
        // few more cycles in which any stray result would be caught.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        wait_idle();
        repeat (2 * DRAIN_CYCLES) @(posedge aclk);
        if (expected_pixels.size() != 0)
            report_mismatch("pixels never returned", 0, expected_pixels.size());

        if (error_count == 0) begin
            $display("tb_pixel_saturation_tone_curve: done, clean");
        end else begin
            $display("tb_pixel_saturation_tone_curve: done, errors");
        end
        $finish;
    end

endmodule
